FILE: rtl/pps_pkg.sv
`timescale 1ns / 1ps

package pps_pkg;

	localparam int unsigned DataW      = 32;
	localparam int unsigned PscW       = 16;
	localparam int unsigned CfgIdxW    = 2;
	localparam int unsigned DivCntW    = 5;

	localparam logic [DataW-1:0]   ClockReset     = 32'd90000000;
	localparam logic [CfgIdxW-1:0] RegTimerClock  = 2'd0;
	localparam logic [CfgIdxW-1:0] RegWideCounter = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV1,
		ST_START2,
		ST_DIV2,
		ST_RESULT
	} pps_state_t;

	typedef struct packed {
		logic capture;
		logic div_start;
		logic div_second;
		logic take_q;
		logic take_period;
		logic load_out;
	} pps_cmd_t;

	typedef struct packed {
		logic req_bad;
		logic wide;
		logic div_busy;
	} pps_stat_t;

endpackage

FILE: rtl/pps_div.sv
`timescale 1ns / 1ps

module pps_div import pps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DataW-1:0] dividend,
	input  logic [DataW-1:0] divisor,
	output logic             busy,
	output logic [DataW-1:0] quotient
);

	logic [DataW-1:0]   rem_q;
	logic [DataW-1:0]   quo_q;
	logic [DataW-1:0]   dsr_q;
	logic [DivCntW-1:0] cnt_q;
	logic               busy_q;
	logic [DataW:0]     shifted;
	logic [DataW:0]     diff;
	logic               ge;

	assign shifted = {rem_q, quo_q[DataW-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign ge      = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + {{(DivCntW-1){1'b0}}, 1'b1};
			if (cnt_q == {DivCntW{1'b1}})
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DataW-1:0] : shifted[DataW-1:0];
			quo_q <= {quo_q[DataW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/pps_datapath.sv
`timescale 1ns / 1ps

module pps_datapath import pps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DataW-1:0]   cfg_data,
	input  logic [DataW-1:0]   request_hz,
	input  pps_cmd_t           cmd,
	output pps_stat_t          stat,
	output logic [PscW-1:0]    prescaler,
	output logic [DataW-1:0]   reload,
	output logic               status
);

	logic [DataW-1:0] clock_q;
	logic             wide_q;
	logic [DataW-1:0] req_q;
	logic             bad_q;
	logic [DataW-1:0] period_q;
	logic [PscW-1:0]  psc_q;
	logic [PscW-1:0]  psc_out_q;
	logic [DataW-1:0] reload_q;
	logic             status_q;
	logic [DataW-1:0] div_a;
	logic [DataW-1:0] div_b;
	logic [PscW:0]    psc_inc;
	logic [DataW-1:0] quo;
	logic             div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= ClockReset;
			wide_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegTimerClock:  clock_q <= cfg_data;
				RegWideCounter: wide_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign psc_inc = {1'b0, psc_q} + {{PscW{1'b0}}, 1'b1};
	assign div_a   = cmd.div_second ? period_q : clock_q;
	assign div_b   = cmd.div_second ? {{(DataW-PscW-1){1'b0}}, psc_inc} : req_q;

	pps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture)
			req_q <= request_hz;
		if (cmd.div_start && !cmd.div_second)
			bad_q <= 1'b0;
		else if (cmd.capture)
			bad_q <= 1'b1;
		if (cmd.take_q) begin
			period_q <= quo;
			psc_q    <= wide_q ? '0 : quo[DataW-1:DataW-PscW];
		end else if (cmd.take_period) begin
			period_q <= quo;
		end
		if (cmd.load_out) begin
			psc_out_q <= bad_q ? '0 : psc_q;
			reload_q  <= bad_q ? '0 : period_q - {{(DataW-1){1'b0}}, 1'b1};
			status_q  <= bad_q;
		end
	end

	assign stat.req_bad  = (req_q == '0) || (req_q > clock_q);
	assign stat.wide     = wide_q;
	assign stat.div_busy = div_busy;

	assign prescaler = psc_out_q;
	assign reload    = reload_q;
	assign status    = status_q;

endmodule

FILE: rtl/pps_ctrl.sv
`timescale 1ns / 1ps

module pps_ctrl import pps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  pps_stat_t stat,
	output pps_cmd_t  cmd
);

	pps_state_t state_q;
	pps_state_t state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.req_bad) begin
					state_d = ST_RESULT;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV1;
				end
			end
			ST_DIV1: begin
				if (!stat.div_busy) begin
					cmd.take_q = 1'b1;
					state_d    = stat.wide ? ST_RESULT : ST_START2;
				end
			end
			ST_START2: begin
				cmd.div_start  = 1'b1;
				cmd.div_second = 1'b1;
				state_d        = ST_DIV2;
			end
			ST_DIV2: begin
				if (!stat.div_busy) begin
					cmd.take_period = 1'b1;
					state_d         = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/pwm_prescaler_reload_solver.sv
`timescale 1ns / 1ps
// From input beat to result valid: an invalid request goes straight to the result, a
// 32-bit counter runs the divider once and a 16-bit counter runs it twice.
// One item at a time: the next beat is taken only after the last result is loaded, which
// waits while a previous result is held under stall; the divider is a 32-step divider.
// Reset clears the controller, empties the output and loads the reset clock and width.
module pwm_prescaler_reload_solver import pps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DataW-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [DataW-1:0]   request_hz,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PscW-1:0]    prescaler,
	output logic [DataW-1:0]   reload,
	output logic               status
);

	pps_cmd_t  cmd;
	pps_stat_t stat;

	assign cfg_ready = 1'b1;

	pps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pps_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.request_hz (request_hz),
		.cmd        (cmd),
		.stat       (stat),
		.prescaler  (prescaler),
		.reload     (reload),
		.status     (status)
	);

endmodule
